// ===== rtl/trct_pkg.sv =====
// Shared types, field widths and codes of the receive connection table.
package trct_pkg;

  localparam int CONNECTIONS         = 8;
  localparam int BUFFER_BYTES        = 4096;
  localparam int SEGMENT_PAYLOAD_MAX = 1024;

  localparam int IDX_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

  localparam int KIND_W = 3;
  localparam int PORT_W = 16;
  localparam int SLOT_W = 3;
  localparam int STYP_W = 2;
  localparam int SEQ_W  = 32;
  localparam int SLEN_W = 11;
  localparam int BUF_W  = 13;
  localparam int STAT_W = 2;
  localparam int RTYP_W = 2;
  localparam int PH_W   = 2;

  localparam logic [KIND_W-1:0] K_OPEN    = 3'd0;
  localparam logic [KIND_W-1:0] K_LISTEN  = 3'd1;
  localparam logic [KIND_W-1:0] K_SEGMENT = 3'd2;
  localparam logic [KIND_W-1:0] K_READ    = 3'd3;
  localparam logic [KIND_W-1:0] K_CLOSE   = 3'd4;

  localparam logic [STYP_W-1:0] SEG_SYN  = 2'd0;
  localparam logic [STYP_W-1:0] SEG_FIN  = 2'd1;
  localparam logic [STYP_W-1:0] SEG_DATA = 2'd2;

  localparam logic [PH_W-1:0] PH_CLOSED = 2'd0;
  localparam logic [PH_W-1:0] PH_LISTEN = 2'd1;
  localparam logic [PH_W-1:0] PH_CONN   = 2'd2;
  localparam logic [PH_W-1:0] PH_CWAIT  = 2'd3;

  localparam logic [RTYP_W-1:0] RP_SYNACK  = 2'd0;
  localparam logic [RTYP_W-1:0] RP_FINACK  = 2'd1;
  localparam logic [RTYP_W-1:0] RP_DATAACK = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FAIL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTREADY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOMATCH  = 2'd3;

  typedef struct packed {
    logic              used;
    logic [PORT_W-1:0] local_port;
    logic [PH_W-1:0]   phase;
    logic [SEQ_W-1:0]  exp_seq;
    logic [PORT_W-1:0] client_port;
    logic [BUF_W-1:0]  buffered;
  } trct_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    trct_entry_t      entry;
  } trct_wr_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] open_port;
    logic [SLOT_W-1:0] slot;
    logic [PORT_W-1:0] seg_dest_port;
    logic [PORT_W-1:0] seg_src_port;
    logic [STYP_W-1:0] seg_type;
    logic [SEQ_W-1:0]  seg_seq;
    logic [SLEN_W-1:0] seg_length;
    logic [BUF_W-1:0]  read_length;
  } trct_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] result_slot;
    logic              reply_valid;
    logic [RTYP_W-1:0] reply_type;
    logic [PORT_W-1:0] reply_src_port;
    logic [PORT_W-1:0] reply_dest_port;
    logic [SEQ_W-1:0]  reply_ack_num;
    logic [BUF_W-1:0]  granted_length;
  } trct_res_t;

endpackage

// ===== rtl/trct_if.sv =====
// Valid/ready channel interfaces for request beats and result beats.
interface trct_in_if import trct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PORT_W-1:0] open_port;
  logic [SLOT_W-1:0] slot;
  logic [PORT_W-1:0] seg_dest_port;
  logic [PORT_W-1:0] seg_src_port;
  logic [STYP_W-1:0] seg_type;
  logic [SEQ_W-1:0]  seg_seq;
  logic [SLEN_W-1:0] seg_length;
  logic [BUF_W-1:0]  read_length;

  modport source (output valid, kind, open_port, slot, seg_dest_port, seg_src_port,
                  seg_type, seg_seq, seg_length, read_length, input ready);
  modport sink (input valid, kind, open_port, slot, seg_dest_port, seg_src_port,
                seg_type, seg_seq, seg_length, read_length, output ready);
endinterface

interface trct_out_if import trct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] result_slot;
  logic              reply_valid;
  logic [RTYP_W-1:0] reply_type;
  logic [PORT_W-1:0] reply_src_port;
  logic [PORT_W-1:0] reply_dest_port;
  logic [SEQ_W-1:0]  reply_ack_num;
  logic [BUF_W-1:0]  granted_length;

  modport source (output valid, status, result_slot, reply_valid, reply_type,
                  reply_src_port, reply_dest_port, reply_ack_num, granted_length,
                  input ready);
  modport sink (input valid, status, result_slot, reply_valid, reply_type,
                reply_src_port, reply_dest_port, reply_ack_num, granted_length,
                output ready);
endinterface

// ===== rtl/trct_table.sv =====
// Connection entry storage: one read port, one write port.
module trct_table import trct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output trct_entry_t      rd_entry,
  input  trct_wr_t         wr
);

  logic [CONNECTIONS-1:0] used_r;
  logic [PORT_W-1:0]      local_port_r  [CONNECTIONS];
  logic [PH_W-1:0]        phase_r       [CONNECTIONS];
  logic [SEQ_W-1:0]       exp_seq_r     [CONNECTIONS];
  logic [PORT_W-1:0]      client_port_r [CONNECTIONS];
  logic [BUF_W-1:0]       buffered_r    [CONNECTIONS];

  // Only the used bits reset; open sets every other field but client_port, which a SYN sets.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr.en) begin
      used_r[wr.idx] <= wr.entry.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      local_port_r[wr.idx]  <= wr.entry.local_port;
      phase_r[wr.idx]       <= wr.entry.phase;
      exp_seq_r[wr.idx]     <= wr.entry.exp_seq;
      client_port_r[wr.idx] <= wr.entry.client_port;
      buffered_r[wr.idx]    <= wr.entry.buffered;
    end
  end

  always_comb begin
    rd_entry.used        = used_r[rd_idx];
    rd_entry.local_port  = local_port_r[rd_idx];
    rd_entry.phase       = phase_r[rd_idx];
    rd_entry.exp_seq     = exp_seq_r[rd_idx];
    rd_entry.client_port = client_port_r[rd_idx];
    rd_entry.buffered    = buffered_r[rd_idx];
  end

endmodule

// ===== rtl/trct_ctrl.sv =====
// Sequencer: port scan with one compare unit, entry update and result register.
module trct_ctrl import trct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  trct_item_t       in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output trct_res_t        out_res,
  output logic [IDX_W-1:0] rd_idx,
  input  trct_entry_t      rd_entry,
  output trct_wr_t         wr
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CONNECTIONS - 1);
  localparam int SUM_W = BUF_W + 1;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0] target_idx_r, target_idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic             hit_found_r, hit_found_nxt;
  logic             slot_ok_r, slot_ok_nxt;
  trct_item_t       item_r, item_nxt;
  logic             out_valid_r, out_valid_nxt;
  trct_res_t        res_r, res_nxt;

  logic [PORT_W-1:0] scan_key;
  logic              scan_hit;
  logic [SUM_W-1:0]  buf_sum;
  logic              data_fit;
  logic              out_free;
  trct_res_t         ex_res;
  trct_wr_t          ex_wr;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign rd_idx    = (state_r == S_SCAN) ? scan_idx_r : target_idx_r;
  assign out_free  = !out_valid_r || out_ready;

  // Shared compare unit for the port lookup.
  assign scan_key = (item_r.kind == K_OPEN) ? item_r.open_port : item_r.seg_dest_port;
  assign scan_hit = rd_entry.used && (rd_entry.local_port == scan_key);

  assign buf_sum  = {1'b0, rd_entry.buffered} + SUM_W'(item_r.seg_length);
  assign data_fit = (item_r.seg_seq == rd_entry.exp_seq) &&
                    (item_r.seg_length <= SEGMENT_PAYLOAD_MAX) &&
                    (buf_sum <= BUFFER_BYTES);

  // Entry update and result for the item in hand.
  always_comb begin
    ex_res        = '0;
    ex_res.status = STAT_FAIL;
    ex_wr.en      = 1'b0;
    ex_wr.idx     = target_idx_r;
    ex_wr.entry   = rd_entry;
    unique case (item_r.kind)
      K_OPEN: begin
        if (!hit_found_r && free_found_r) begin
          ex_wr.en               = 1'b1;
          ex_wr.entry.used       = 1'b1;
          ex_wr.entry.local_port = item_r.open_port;
          ex_wr.entry.phase      = PH_CLOSED;
          ex_wr.entry.exp_seq    = '0;
          ex_wr.entry.buffered   = '0;
          ex_res.status          = STAT_OK;
          ex_res.result_slot     = SLOT_W'(target_idx_r);
        end
      end
      K_LISTEN: begin
        if (slot_ok_r && rd_entry.used && rd_entry.phase == PH_CLOSED) begin
          ex_wr.en          = 1'b1;
          ex_wr.entry.phase = PH_LISTEN;
          ex_res.status     = STAT_OK;
        end
      end
      K_SEGMENT: begin
        if (!hit_found_r) begin
          ex_res.status = STAT_NOMATCH;
        end else begin
          ex_res.result_slot = SLOT_W'(target_idx_r);
          case (rd_entry.phase)
            PH_LISTEN: begin
              if (item_r.seg_type == SEG_SYN) begin
                ex_wr.en                = 1'b1;
                ex_wr.entry.phase       = PH_CONN;
                ex_wr.entry.exp_seq     = item_r.seg_seq;
                ex_wr.entry.client_port = item_r.seg_src_port;
                ex_res.reply_valid      = 1'b1;
                ex_res.reply_type       = RP_SYNACK;
              end
            end
            PH_CONN: begin
              if (item_r.seg_type == SEG_SYN) begin
                ex_res.reply_valid = 1'b1;
                ex_res.reply_type  = RP_SYNACK;
              end else if (item_r.seg_type == SEG_FIN) begin
                ex_wr.en           = 1'b1;
                ex_wr.entry.phase  = PH_CWAIT;
                ex_res.reply_valid = 1'b1;
                ex_res.reply_type  = RP_FINACK;
              end else if (item_r.seg_type == SEG_DATA) begin
                // Out-of-order, oversized or overflowing data is only acknowledged.
                if (data_fit) begin
                  ex_wr.en             = 1'b1;
                  ex_wr.entry.buffered = buf_sum[BUF_W-1:0];
                  ex_wr.entry.exp_seq  = rd_entry.exp_seq + SEQ_W'(item_r.seg_length);
                end
                ex_res.reply_valid   = 1'b1;
                ex_res.reply_type    = RP_DATAACK;
                ex_res.reply_ack_num = ex_wr.entry.exp_seq;
              end
            end
            PH_CWAIT: begin
              if (item_r.seg_type == SEG_FIN) begin
                ex_wr.en           = 1'b1;
                ex_wr.entry.phase  = PH_CLOSED;
                ex_res.reply_valid = 1'b1;
                ex_res.reply_type  = RP_FINACK;
              end
            end
            default: begin
            end
          endcase
          if (ex_res.reply_valid) begin
            ex_res.status          = STAT_OK;
            ex_res.reply_src_port  = ex_wr.entry.local_port;
            ex_res.reply_dest_port = ex_wr.entry.client_port;
          end
        end
      end
      K_READ: begin
        if (slot_ok_r && rd_entry.used && rd_entry.phase == PH_CONN) begin
          if (rd_entry.buffered >= item_r.read_length) begin
            ex_wr.en              = 1'b1;
            ex_wr.entry.buffered  = rd_entry.buffered - item_r.read_length;
            ex_res.status         = STAT_OK;
            ex_res.granted_length = item_r.read_length;
          end else begin
            ex_res.status = STAT_NOTREADY;
          end
        end
      end
      K_CLOSE: begin
        if (slot_ok_r && rd_entry.used && rd_entry.phase == PH_CLOSED) begin
          ex_wr.en         = 1'b1;
          ex_wr.entry.used = 1'b0;
          ex_res.status    = STAT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    target_idx_nxt = target_idx_r;
    free_found_nxt = free_found_r;
    hit_found_nxt  = hit_found_r;
    slot_ok_nxt    = slot_ok_r;
    item_nxt       = item_r;
    out_valid_nxt  = out_valid_r;
    res_nxt        = res_r;
    wr             = ex_wr;
    wr.en          = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = in_item;
          slot_ok_nxt    = ({29'd0, in_item.slot} < CONNECTIONS);
          free_found_nxt = 1'b0;
          hit_found_nxt  = 1'b0;
          scan_idx_nxt   = '0;
          target_idx_nxt = IDX_W'(in_item.slot);
          if (in_item.kind == K_OPEN || in_item.kind == K_SEGMENT) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          hit_found_nxt  = 1'b1;
          target_idx_nxt = scan_idx_r;
          state_nxt      = S_EXEC;
        end else begin
          // Remember the first free entry for open.
          if (!rd_entry.used && !free_found_r) begin
            free_found_nxt = 1'b1;
            target_idx_nxt = scan_idx_r;
          end
          if (scan_idx_r == LAST_IDX) begin
            state_nxt = S_EXEC;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
      end
      S_EXEC: begin
        // Hold until the result register is free.
        if (out_free) begin
          wr            = ex_wr;
          res_nxt       = ex_res;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    target_idx_r <= target_idx_nxt;
    free_found_r <= free_found_nxt;
    hit_found_r  <= hit_found_nxt;
    slot_ok_r    <= slot_ok_nxt;
    item_r       <= item_nxt;
    res_r        <= res_nxt;
  end

endmodule

// ===== rtl/transport_receiver_connection_table_top.sv =====
// Top level of the receive-side transport connection table.
//
// Request beats arrive on in_ch (valid/ready): open, listen, segment, read or
// close. Each request gives exactly one result beat on out_ch, in order.
// Open and segment requests look up the server port by walking the table one
// entry per cycle through a single compare unit; listen, read and close go
// straight to the entry named by slot.
// Open and segment requests go through the scan state, which stops at the
// first hit or after the last entry, then the execute state; listen, read
// and close go straight to the execute state. The entry scan over the
// table's single read port makes open and segment slower. One request is in
// work at a time: in_ch.ready is high only while the sequencer is idle.
// The result sits in an output register; while out_ch stalls, the block still
// takes the next request and scans, then holds its update until the register
// frees, so no beat is lost.
// Reset (rst_n low, synchronous) empties the table at once by clearing the
// used bits and drops any pending result beat; no clearing pass is needed.
module transport_receiver_connection_table_top import trct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  trct_in_if.sink     in_ch,
  trct_out_if.source  out_ch
);

  trct_item_t       in_item;
  trct_res_t        out_res;
  logic [IDX_W-1:0] rd_idx;
  trct_entry_t      rd_entry;
  trct_wr_t         wr;

  // Pack the request beat.
  always_comb begin
    in_item.kind          = in_ch.kind;
    in_item.open_port     = in_ch.open_port;
    in_item.slot          = in_ch.slot;
    in_item.seg_dest_port = in_ch.seg_dest_port;
    in_item.seg_src_port  = in_ch.seg_src_port;
    in_item.seg_type      = in_ch.seg_type;
    in_item.seg_seq       = in_ch.seg_seq;
    in_item.seg_length    = in_ch.seg_length;
    in_item.read_length   = in_ch.read_length;
  end

  trct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res),
    .rd_idx    (rd_idx),
    .rd_entry  (rd_entry),
    .wr        (wr)
  );

  trct_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  // Unpack the result beat.
  assign out_ch.status          = out_res.status;
  assign out_ch.result_slot     = out_res.result_slot;
  assign out_ch.reply_valid     = out_res.reply_valid;
  assign out_ch.reply_type      = out_res.reply_type;
  assign out_ch.reply_src_port  = out_res.reply_src_port;
  assign out_ch.reply_dest_port = out_res.reply_dest_port;
  assign out_ch.reply_ack_num   = out_res.reply_ack_num;
  assign out_ch.granted_length  = out_res.granted_length;

endmodule

// ===== rtl/trct_top_chk.sv =====
// Port-level checker for the connection table top, bound to the top level.
module trct_top_chk import trct_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] status,
  input logic [SLOT_W-1:0] result_slot,
  input logic              reply_valid,
  input logic [BUF_W-1:0]  granted_length
);

  // A result beat holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // One request at a time: busy right after an accepted beat.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_reply_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && reply_valid |-> status == STAT_OK)
    else $error("reply with non-ok status");

  a_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_NOMATCH |->
      !reply_valid && result_slot == '0 && granted_length == '0)
    else $error("unmatched segment carries reply fields");

  a_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && granted_length != '0 |-> status == STAT_OK && !reply_valid)
    else $error("grant with bad status or reply");

endmodule

bind transport_receiver_connection_table_top trct_top_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .result_slot    (out_ch.result_slot),
  .reply_valid    (out_ch.reply_valid),
  .granted_length (out_ch.granted_length)
);

// ===== tb/trct_reply_tracker.sv =====
// Watches both channels, predicts each result beat of the connection table and compares it.
module trct_reply_tracker import trct_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  trct_in_if                            in_ch,
  trct_out_if                           out_ch,
  output trct_entry_t [CONNECTIONS-1:0] table_view,
  output int                            pending_results,
  output int                            fail_count,
  output int                            req_count,
  output int                            result_count,
  output int                            reply_count,
  output int                            grant_count
);

  typedef struct packed {
    trct_res_t   res;
    logic [31:0] beat_no;
  } awaited_t;

  trct_entry_t [CONNECTIONS-1:0] conn_state;
  awaited_t                      awaited_replies[$];
  int                            fails;
  int                            n_req;
  int                            n_res;
  int                            n_reply;
  int                            n_grant;

  initial begin
    fails   = 0;
    n_req   = 0;
    n_res   = 0;
    n_reply = 0;
    n_grant = 0;
  end

  // Advance the table by one request and return the result beat it must give.
  function automatic trct_res_t apply_request(input trct_item_t it);
    trct_res_t         r;
    int                s;
    int                m;
    logic              slot_ok;
    logic              taken;
    logic              answer;
    logic [RTYP_W-1:0] rtype;
    r       = '0;
    r.status = STAT_FAIL;
    s       = int'(it.slot);
    m       = -1;
    slot_ok = 1'b0;
    taken   = 1'b0;
    answer  = 1'b0;
    rtype   = RP_SYNACK;
    if (s < CONNECTIONS) slot_ok = conn_state[s].used;
    case (it.kind)
      K_OPEN: begin
        for (int i = 0; i < CONNECTIONS; i++)
          if (conn_state[i].used && conn_state[i].local_port == it.open_port) taken = 1'b1;
        for (int i = 0; i < CONNECTIONS; i++)
          if (!taken && m < 0 && !conn_state[i].used) m = i;
        if (m >= 0) begin
          conn_state[m].used       = 1'b1;
          conn_state[m].local_port = it.open_port;
          conn_state[m].phase      = PH_CLOSED;
          conn_state[m].exp_seq    = '0;
          conn_state[m].buffered   = '0;
          r.status      = STAT_OK;
          r.result_slot = SLOT_W'(m);
        end
      end
      K_LISTEN: begin
        if (slot_ok && conn_state[s].phase == PH_CLOSED) begin
          conn_state[s].phase = PH_LISTEN;
          r.status = STAT_OK;
        end
      end
      K_SEGMENT: begin
        for (int i = 0; i < CONNECTIONS; i++)
          if (m < 0 && conn_state[i].used &&
              conn_state[i].local_port == it.seg_dest_port) m = i;
        if (m < 0) begin
          r.status = STAT_NOMATCH;
        end else begin
          r.result_slot = SLOT_W'(m);
          case (conn_state[m].phase)
            PH_LISTEN: begin
              if (it.seg_type == SEG_SYN) begin
                conn_state[m].phase       = PH_CONN;
                conn_state[m].exp_seq     = it.seg_seq;
                conn_state[m].client_port = it.seg_src_port;
                answer = 1'b1;
              end
            end
            PH_CONN: begin
              case (it.seg_type)
                SEG_SYN: answer = 1'b1;
                SEG_FIN: begin
                  conn_state[m].phase = PH_CWAIT;
                  rtype  = RP_FINACK;
                  answer = 1'b1;
                end
                SEG_DATA: begin
                  // accept only in-order data that fits; anything else is just acked
                  if (it.seg_seq == conn_state[m].exp_seq &&
                      it.seg_length <= SEGMENT_PAYLOAD_MAX &&
                      int'(conn_state[m].buffered) + int'(it.seg_length) <= BUFFER_BYTES) begin
                    conn_state[m].buffered = conn_state[m].buffered + BUF_W'(it.seg_length);
                    conn_state[m].exp_seq  = conn_state[m].exp_seq + SEQ_W'(it.seg_length);
                  end
                  rtype  = RP_DATAACK;
                  answer = 1'b1;
                end
                default: ;
              endcase
            end
            PH_CWAIT: begin
              // a FIN in close-wait closes the entry
              if (it.seg_type == SEG_FIN) begin
                conn_state[m].phase = PH_CLOSED;
                rtype  = RP_FINACK;
                answer = 1'b1;
              end
            end
            default: ;
          endcase
          if (answer) begin
            r.status          = STAT_OK;
            r.reply_valid     = 1'b1;
            r.reply_type      = rtype;
            r.reply_src_port  = conn_state[m].local_port;
            r.reply_dest_port = conn_state[m].client_port;
            if (rtype == RP_DATAACK) r.reply_ack_num = conn_state[m].exp_seq;
          end
        end
      end
      K_READ: begin
        if (slot_ok && conn_state[s].phase == PH_CONN) begin
          if (conn_state[s].buffered >= it.read_length) begin
            conn_state[s].buffered = conn_state[s].buffered - it.read_length;
            r.status         = STAT_OK;
            r.granted_length = it.read_length;
          end else begin
            r.status = STAT_NOTREADY;
          end
        end
      end
      K_CLOSE: begin
        if (slot_ok && conn_state[s].phase == PH_CLOSED) begin
          conn_state[s].used = 1'b0;
          r.status = STAT_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] beat_no,
                                      input logic [31:0] want_v, input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: beat %0d %s mismatch, expected 0x%0h, got 0x%0h",
               $time, beat_no, name, want_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : watch
    trct_item_t it;
    trct_res_t  got;
    awaited_t   head;
    if (!rst_n) begin
      conn_state = '0;
      awaited_replies.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.result_slot, out_ch.reply_valid, out_ch.reply_type,
               out_ch.reply_src_port, out_ch.reply_dest_port, out_ch.reply_ack_num,
               out_ch.granted_length};
        n_res++;
        if (awaited_replies.size() == 0) begin
          $display("%0t: result beat with nothing outstanding, expected none, got 0x%0h",
                   $time, got);
          fails++;
        end else begin
          head = awaited_replies.pop_front();
          check_field("status", head.beat_no, 32'(head.res.status), 32'(got.status));
          check_field("result_slot", head.beat_no, 32'(head.res.result_slot),
                      32'(got.result_slot));
          check_field("reply_valid", head.beat_no, 32'(head.res.reply_valid),
                      32'(got.reply_valid));
          check_field("reply_type", head.beat_no, 32'(head.res.reply_type),
                      32'(got.reply_type));
          check_field("reply_src_port", head.beat_no, 32'(head.res.reply_src_port),
                      32'(got.reply_src_port));
          check_field("reply_dest_port", head.beat_no, 32'(head.res.reply_dest_port),
                      32'(got.reply_dest_port));
          check_field("reply_ack_num", head.beat_no, head.res.reply_ack_num,
                      got.reply_ack_num);
          check_field("granted_length", head.beat_no, 32'(head.res.granted_length),
                      32'(got.granted_length));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it = {in_ch.kind, in_ch.open_port, in_ch.slot, in_ch.seg_dest_port,
              in_ch.seg_src_port, in_ch.seg_type, in_ch.seg_seq, in_ch.seg_length,
              in_ch.read_length};
        head.res     = apply_request(it);
        head.beat_no = n_req;
        awaited_replies.push_back(head);
        n_req++;
        if (head.res.reply_valid) n_reply++;
        if (it.kind == K_READ && head.res.status == STAT_OK) n_grant++;
      end
    end
    table_view      <= conn_state;
    pending_results <= awaited_replies.size();
    fail_count      <= fails;
    req_count       <= n_req;
    result_count    <= n_res;
    reply_count     <= n_reply;
    grant_count     <= n_grant;
  end

endmodule

// ===== tb/transport_receiver_connection_table_top_tb.sv =====
// Stimulus, clock, reset and verdict for the receive connection table.
module transport_receiver_connection_table_top_tb;
  import trct_pkg::*;

  localparam int RANDOM_BEATS = 1330;
  localparam int TAIL_BEATS   = 150;
  localparam int LONG_HOLD    = 150;
  localparam int POOL_SIZE    = 10;
  localparam int HOLD_AT      = 400;
  localparam int DRAIN_AT     = 800;

  localparam logic [PORT_W-1:0] PORT_LO   = 16'h0000;
  localparam logic [PORT_W-1:0] PORT_HI   = 16'hFFFF;
  localparam logic [STYP_W-1:0] SEG_OTHER = 2'd3;
  localparam logic [KIND_W-1:0] K_UNKNOWN = 3'd7;

  logic clk;
  logic rst_n;

  trct_in_if  in_ch ();
  trct_out_if out_ch ();

  trct_entry_t [CONNECTIONS-1:0] table_view;
  int                            pending_results;
  int                            fail_count;
  int                            req_count;
  int                            result_count;
  int                            reply_count;
  int                            grant_count;

  // Idle chances in percent; the sink one is read by the ready process.
  int src_idle_pct;
  int sink_idle_pct;
  // Bumped once to ask the ready process for a long hold-off.
  int hold_asks;

  logic [PORT_W-1:0] port_pool [POOL_SIZE];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  transport_receiver_connection_table_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  trct_reply_tracker tracker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .table_view      (table_view),
    .pending_results (pending_results),
    .fail_count      (fail_count),
    .req_count       (req_count),
    .result_count    (result_count),
    .reply_count     (reply_count),
    .grant_count     (grant_count)
  );

  // Fill every field with random bits; callers overwrite what matters.
  // Half the segment lookups aim at ports that the table is likely to hold.
  function automatic trct_item_t noise_item();
    trct_item_t it;
    it.kind          = KIND_W'($urandom_range(0, 7));
    it.open_port     = PORT_W'($urandom);
    it.slot          = SLOT_W'($urandom);
    it.seg_dest_port = ($urandom_range(0, 1) != 0) ? port_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : PORT_W'($urandom);
    it.seg_src_port  = PORT_W'($urandom);
    it.seg_type      = STYP_W'($urandom);
    it.seg_seq       = $urandom;
    it.seg_length    = SLEN_W'($urandom);
    it.read_length   = BUF_W'($urandom);
    return it;
  endfunction

  function automatic trct_item_t req_open(input logic [PORT_W-1:0] port);
    trct_item_t it;
    it = noise_item();
    it.kind      = K_OPEN;
    it.open_port = port;
    return it;
  endfunction

  function automatic trct_item_t req_slot(input logic [KIND_W-1:0] kind,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [BUF_W-1:0]  rlen);
    trct_item_t it;
    it = noise_item();
    it.kind        = kind;
    it.slot        = slot;
    it.read_length = rlen;
    return it;
  endfunction

  function automatic trct_item_t req_seg(input logic [PORT_W-1:0] dest,
                                         input logic [PORT_W-1:0] src,
                                         input logic [STYP_W-1:0] typ,
                                         input logic [SEQ_W-1:0]  seq,
                                         input logic [SLEN_W-1:0] len);
    trct_item_t it;
    it = noise_item();
    it.kind          = K_SEGMENT;
    it.seg_dest_port = dest;
    it.seg_src_port  = src;
    it.seg_type      = typ;
    it.seg_seq       = seq;
    it.seg_length    = len;
    return it;
  endfunction

  // Pick a random used entry in the given phase, or -1 if there is none.
  function automatic int pick_slot(input logic [PH_W-1:0] ph);
    int hits[$];
    for (int i = 0; i < CONNECTIONS; i++)
      if (table_view[i].used && table_view[i].phase == ph) hits.push_back(i);
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  // Offer one beat: optional idle burst, hold valid until the handshake, then
  // drop valid and wait for the clock again so the predicted table is current.
  task automatic send_beat(input trct_item_t it);
    int gap;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    {in_ch.kind, in_ch.open_port, in_ch.slot, in_ch.seg_dest_port, in_ch.seg_src_port,
     in_ch.seg_type, in_ch.seg_seq, in_ch.seg_length, in_ch.read_length} <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request. The
  // hold is counted here so the sender keeps offering beats meanwhile and the
  // block backs up into its input.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int holds_done;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    hold_left    = 0;
    holds_done   = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (holds_done != hold_asks) begin
        holds_done++;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        stall_left = $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    trct_item_t it;
    int         dice;
    int         e;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.kind, in_ch.open_port, in_ch.slot, in_ch.seg_dest_port, in_ch.seg_src_port,
     in_ch.seg_type, in_ch.seg_seq, in_ch.seg_length, in_ch.read_length} = '0;
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    hold_asks     = 0;
    // Port pool: the two extremes plus random ports. More ports than entries,
    // so opens collide with ports in use and also find the table full.
    port_pool[0] = PORT_LO;
    port_pool[1] = PORT_HI;
    for (int i = 2; i < POOL_SIZE; i++) port_pool[i] = PORT_W'($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through one connection's life on entry 0.
    send_beat(req_slot(K_READ, 3'd7, 13'h1FFF));                      // unused entry
    send_beat(req_open(PORT_LO));
    send_beat(req_open(PORT_LO));                                     // port in use
    send_beat(req_open(PORT_HI));
    send_beat(req_seg(16'h1234, 16'h0001, SEG_SYN, 32'h0, 11'd0));    // no such port
    send_beat(req_seg(PORT_LO, 16'h0001, SEG_SYN, 32'h0, 11'd0));     // SYN while closed
    send_beat(req_slot(K_LISTEN, 3'd0, 13'd0));
    send_beat(req_slot(K_LISTEN, 3'd0, 13'd0));                       // not from closed
    send_beat(req_seg(PORT_LO, 16'h0001, SEG_OTHER, 32'h0, 11'd0));   // other type ignored
    send_beat(req_seg(PORT_LO, 16'hFFFF, SEG_SYN, 32'hFFFF_FC00, 11'd0));
    send_beat(req_seg(PORT_LO, 16'h0000, SEG_SYN, 32'h0, 11'd0));     // SYN again
    // In order, wraps the sequence number to zero.
    send_beat(req_seg(PORT_LO, 16'h0000, SEG_DATA, 32'hFFFF_FC00, 11'd1024));
    send_beat(req_seg(PORT_LO, 16'h0000, SEG_DATA, 32'd5, 11'd10));   // out of order
    send_beat(req_seg(PORT_LO, 16'h0000, SEG_DATA, 32'd0, 11'd2047)); // oversized
    // Fill the buffer to the brim, then overflow it by one byte.
    send_beat(req_seg(PORT_LO, 16'h0000, SEG_DATA, 32'd0, 11'd1024));
    send_beat(req_seg(PORT_LO, 16'h0000, SEG_DATA, 32'd1024, 11'd1024));
    send_beat(req_seg(PORT_LO, 16'h0000, SEG_DATA, 32'd2048, 11'd1024));
    send_beat(req_seg(PORT_LO, 16'h0000, SEG_DATA, 32'd3072, 11'd1));
    send_beat(req_slot(K_READ, 3'd0, 13'h1FFF));                      // not enough buffered
    send_beat(req_slot(K_READ, 3'd0, 13'd4096));
    send_beat(req_slot(K_CLOSE, 3'd0, 13'd0));                        // still connected
    send_beat(req_seg(PORT_LO, 16'h0000, SEG_FIN, 32'h0, 11'd0));
    send_beat(req_seg(PORT_LO, 16'h0000, SEG_FIN, 32'h0, 11'd0));     // FIN closes from close-wait
    send_beat(req_slot(K_CLOSE, 3'd0, 13'd0));
    send_beat(req_slot(K_UNKNOWN, 3'd1, 13'd0));
    send_beat(req_slot(K_READ, 3'd1, 13'd0));                         // read while closed

    // Random part: mostly well-formed steps aimed at entries in the right
    // phase, with random content; the rest is noise across all fields.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) begin
        if (n >= RANDOM_BEATS - TAIL_BEATS) begin
          src_idle_pct  = 0;
          sink_idle_pct <= 0;
        end else begin
          src_idle_pct  = 15 * $urandom_range(0, 3);
          sink_idle_pct <= 15 * $urandom_range(0, 3);
        end
      end
      if (n == HOLD_AT) hold_asks <= hold_asks + 1;
      if (n == DRAIN_AT) begin
        // hold the sender until every outstanding result has come back
        while (pending_results != 0) @(posedge clk);
      end
      dice = $urandom_range(0, 99);
      it = noise_item();
      if (dice < 12) begin
        it.kind      = K_OPEN;
        it.open_port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (dice < 21) begin
        it.kind = K_LISTEN;
        e = pick_slot(PH_CLOSED);
        if (e >= 0) it.slot = SLOT_W'(e);
      end else if (dice < 31) begin
        it.kind     = K_SEGMENT;
        it.seg_type = SEG_SYN;
        e = pick_slot(PH_LISTEN);
        if (e >= 0) it.seg_dest_port = table_view[e].local_port;
      end else if (dice < 56) begin
        it.kind     = K_SEGMENT;
        it.seg_type = SEG_DATA;
        e = pick_slot(PH_CONN);
        if (e >= 0) begin
          it.seg_dest_port = table_view[e].local_port;
          if ($urandom_range(0, 9) != 0) it.seg_seq = table_view[e].exp_seq;
        end
        // mostly legal sizes, now and then past the payload limit
        if ($urandom_range(0, 19) == 0) it.seg_length = SLEN_W'($urandom_range(1025, 2047));
        else it.seg_length = SLEN_W'($urandom_range(0, 600));
      end else if (dice < 71) begin
        it.kind = K_READ;
        e = pick_slot(PH_CONN);
        if (e >= 0) begin
          it.slot = SLOT_W'(e);
          if ($urandom_range(0, 4) != 0)
            it.read_length = BUF_W'($urandom_range(0, table_view[e].buffered));
        end
      end else if (dice < 79) begin
        it.kind     = K_SEGMENT;
        it.seg_type = SEG_FIN;
        e = ($urandom_range(0, 1) != 0) ? pick_slot(PH_CONN) : pick_slot(PH_CWAIT);
        if (e >= 0) it.seg_dest_port = table_view[e].local_port;
      end else if (dice < 87) begin
        it.kind = K_CLOSE;
        e = pick_slot(PH_CLOSED);
        if (e >= 0) it.slot = SLOT_W'(e);
      end
      send_beat(it);
    end

    // Drain, then give the block time to show any stray beat.
    while (pending_results != 0) @(posedge clk);
    repeat (4 * CONNECTIONS) @(posedge clk);
    $display("Covered %0d requests and %0d checked results: %0d segment replies,",
             req_count, result_count, reply_count);
    $display("%0d reads granted, with a long result stall, a full drain pause and %s",
             grant_count, "idle-free traffic at the end.");
    if (fail_count == 0) begin
      $display("transport_receiver_connection_table_top regression: pass");
    end else begin
      $display("transport_receiver_connection_table_top regression: fail");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #6_000_000;
    $display("transport_receiver_connection_table_top regression: fail");
    $finish;
  end

endmodule

// ===== transport_receiver_connection_table_top.f =====
rtl/trct_pkg.sv
rtl/trct_if.sv
rtl/trct_table.sv
rtl/trct_ctrl.sv
rtl/transport_receiver_connection_table_top.sv
rtl/trct_top_chk.sv
tb/trct_reply_tracker.sv
tb/transport_receiver_connection_table_top_tb.sv
